// ===== rtl/u8mu7_pkg.sv =====
// ----------------------------------------------------------------------------
// u8mu7_pkg
// Shared types, constants and the base64 alphabet for the modified UTF-7
// encoder.
// ----------------------------------------------------------------------------
package u8mu7_pkg;

    localparam int MAX_RES = 6;
    localparam int RES_W   = $clog2(MAX_RES + 1);

    localparam logic [6:0] SEP_RESET  = 7'd47;   // '/'
    localparam logic [6:0] CH_AMP     = 7'h26;   // '&'
    localparam logic [6:0] CH_DASH    = 7'h2D;   // '-'
    localparam logic [6:0] CH_UPPER_A = 7'h41;   // 'A'

    localparam logic [15:0] CP_REPLACE = 16'hFFFE;

    // how far the next 16-bit unit is shifted to meet the pending bits
    typedef enum logic [1:0] {
        PH_S10 = 2'd0,
        PH_S14 = 2'd1,
        PH_S12 = 2'd2
    } phase_t;

    typedef logic [6:0] char_t;

    // base64 alphabet with ',' in place of '/'
    function automatic char_t b64_char(input logic [5:0] v);
        char_t r;
        priority if (v < 6'd26)
            r = 7'h41 + 7'(v);
        else if (v < 6'd52)
            r = 7'h61 + 7'(v - 6'd26);
        else if (v < 6'd62)
            r = 7'h30 + 7'(v - 6'd52);
        else if (v == 6'd62)
            r = 7'h2B;
        else
            r = 7'h2C;
        return r;
    endfunction

endpackage

// ===== rtl/u8mu7_byte_if.sv =====
// ----------------------------------------------------------------------------
// u8mu7_byte_if
// Input channel: one UTF-8 byte per word with an end-of-name flag.
// ----------------------------------------------------------------------------
interface u8mu7_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       name_end;

    modport source (output valid, output in_byte, output name_end, input ready);
    modport sink   (input valid, input in_byte, input name_end, output ready);
endinterface

// ===== rtl/u8mu7_char_if.sv =====
// ----------------------------------------------------------------------------
// u8mu7_char_if
// Output channel: one modified UTF-7 character per word with framing flags.
// ----------------------------------------------------------------------------
interface u8mu7_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;
    logic       out_end;
    logic       bad_input;

    modport source (output valid, output out_char, output run_last,
                    output out_end, output bad_input, input ready);
    modport sink   (input valid, input out_char, input run_last,
                    input out_end, input bad_input, output ready);
endinterface

// ===== rtl/utf8_to_modified_utf7_encoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_modified_utf7_encoder
// UTF-8 name component in, IMAP modified UTF-7 characters out.
// ----------------------------------------------------------------------------
// Each accepted byte is decoded and encoded in the cycle it is taken; the
// characters it causes (zero to five) land in a result buffer that drains one
// character per cycle while the output is ready. A byte that causes k
// characters holds the block until all k have left the single output
// port; a byte that causes nothing (a lead or inner continuation byte, or
// a byte dropped after an error) writes nothing to the buffer. The next
// byte is taken in the same cycle the last buffered character leaves, so
// a stream of plain ASCII runs at one byte per cycle while the output is
// ready. Malformed UTF-8 gives a single word with bad_input set, and bytes
// are then dropped up to and including the one marked name_end. The
// separator register may be written only while the block is idle.
module utf8_to_modified_utf7_encoder
    import u8mu7_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    u8mu7_byte_if.sink         byte_ch,
    u8mu7_char_if.source       char_ch,
    input  logic               wr_en,
    input  logic [6:0]         wr_data
);

    // configuration and component state
    logic [6:0]       sep_reg;
    logic             b64_reg,  b64_next;
    logic [5:0]       carry_reg, carry_next;
    phase_t           phase_reg, phase_next;
    logic [30:0]      acc_reg,  acc_next;
    logic [2:0]       cl_reg,   cl_next;
    logic [2:0]       seq_reg,  seq_next;
    logic             disc_reg, disc_next;

    // result buffer
    char_t            chars_reg [MAX_RES];
    logic [RES_W-1:0] cnt_reg;
    logic [2:0]       idx_reg;
    logic             end_reg;
    logic             bad_reg;
    logic             vld_reg;

    // per-byte results
    char_t            ch_v [MAX_RES];
    logic [RES_W-1:0] n_v;
    logic             bad_v;
    logic             do_fail, do_emit, do_sep, overlong;
    logic [30:0]      cp, cont_data;
    logic [15:0]      u16;
    logic [7:0]       c;
    logic             eon;

    logic             last_now, out_fire, in_fire;

    assign c         = byte_ch.in_byte;
    assign eon       = byte_ch.name_end;
    assign cont_data = {acc_reg[24:0], c[5:0]};

    always_comb
    begin
        unique case (seq_reg)
            3'd2:    overlong = (cont_data[30:11] == '0);
            3'd3:    overlong = (cont_data[30:16] == '0);
            3'd4:    overlong = (cont_data[30:21] == '0);
            3'd5:    overlong = (cont_data[30:26] == '0);
            default: overlong = 1'b0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RES; i++)
            ch_v[i] = '0;
        n_v        = '0;
        bad_v      = 1'b0;
        do_fail    = 1'b0;
        do_emit    = 1'b0;
        do_sep     = 1'b0;
        cp         = '0;
        u16        = '0;
        b64_next   = b64_reg;
        carry_next = carry_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cl_next    = cl_reg;
        seq_next   = seq_reg;
        disc_next  = disc_reg;

        // decode
        if (disc_reg)
        begin
            if (eon)
            begin
                disc_next  = 1'b0;
                b64_next   = 1'b0;
                carry_next = '0;
                phase_next = PH_S10;
                acc_next   = '0;
                cl_next    = '0;
                seq_next   = '0;
            end
        end
        else if (cl_reg == 3'd0)
        begin
            if (!b64_reg && c == {1'b0, sep_reg})
                do_sep = 1'b1;
            else if (!c[7])
            begin
                do_emit = 1'b1;
                cp      = 31'(c);
            end
            else if (c < 8'hC2 || c >= 8'hFE)
                do_fail = 1'b1;
            else
            begin
                priority if (c < 8'hE0)
                begin
                    acc_next = 31'(c[4:0]);
                    seq_next = 3'd1;
                end
                else if (c < 8'hF0)
                begin
                    acc_next = 31'(c[3:0]);
                    seq_next = 3'd2;
                end
                else if (c < 8'hF8)
                begin
                    acc_next = 31'(c[2:0]);
                    seq_next = 3'd3;
                end
                else if (c < 8'hFC)
                begin
                    acc_next = 31'(c[1:0]);
                    seq_next = 3'd4;
                end
                else
                begin
                    acc_next = 31'(c[0]);
                    seq_next = 3'd5;
                end
                cl_next = seq_next;
                if (eon)
                    do_fail = 1'b1;
            end
        end
        else
        begin
            if (c[7:6] != 2'b10)
                do_fail = 1'b1;
            else
            begin
                acc_next = cont_data;
                cl_next  = cl_reg - 3'd1;
                if (cl_next != 3'd0)
                begin
                    if (eon)
                        do_fail = 1'b1;
                end
                else if (overlong)
                    do_fail = 1'b1;
                else
                begin
                    do_emit  = 1'b1;
                    cp       = cont_data;
                    acc_next = '0;
                    seq_next = '0;
                end
            end
        end

        // encode
        if (do_fail)
        begin
            n_v        = RES_W'(1);
            bad_v      = 1'b1;
            b64_next   = 1'b0;
            carry_next = '0;
            phase_next = PH_S10;
            acc_next   = '0;
            cl_next    = '0;
            seq_next   = '0;
            disc_next  = !eon;
        end
        else if (!disc_reg)
        begin
            if (do_sep)
            begin
                ch_v[0] = CH_AMP;
                ch_v[1] = CH_UPPER_A;
                ch_v[2] = b64_char({2'b00, c[7:4]});
                ch_v[3] = b64_char({c[3:0], 2'b00});
                ch_v[4] = CH_DASH;
                n_v     = RES_W'(5);
            end
            if (do_emit)
            begin
                if (cp < 31'h20 || cp >= 31'h7F)
                begin
                    if (!b64_next)
                    begin
                        ch_v[n_v]  = CH_AMP;
                        n_v        = n_v + RES_W'(1);
                        b64_next   = 1'b1;
                        carry_next = '0;
                        phase_next = PH_S10;
                    end
                    u16 = (cp > 31'hFFFF) ? CP_REPLACE : cp[15:0];
                    unique case (phase_next)
                        PH_S14:
                        begin
                            ch_v[n_v]  = b64_char(carry_next | {4'b0, u16[15:14]});
                            n_v        = n_v + RES_W'(1);
                            ch_v[n_v]  = b64_char(u16[13:8]);
                            n_v        = n_v + RES_W'(1);
                            ch_v[n_v]  = b64_char(u16[7:2]);
                            n_v        = n_v + RES_W'(1);
                            carry_next = {u16[1:0], 4'b0};
                            phase_next = PH_S12;
                        end
                        PH_S12:
                        begin
                            ch_v[n_v]  = b64_char(carry_next | {2'b0, u16[15:12]});
                            n_v        = n_v + RES_W'(1);
                            ch_v[n_v]  = b64_char(u16[11:6]);
                            n_v        = n_v + RES_W'(1);
                            ch_v[n_v]  = b64_char(u16[5:0]);
                            n_v        = n_v + RES_W'(1);
                            carry_next = '0;
                            phase_next = PH_S10;
                        end
                        default:
                        begin
                            ch_v[n_v]  = b64_char(carry_next | u16[15:10]);
                            n_v        = n_v + RES_W'(1);
                            ch_v[n_v]  = b64_char(u16[9:4]);
                            n_v        = n_v + RES_W'(1);
                            carry_next = {u16[3:0], 2'b0};
                            phase_next = PH_S14;
                        end
                    endcase
                end
                else
                begin
                    if (b64_next)
                    begin
                        if (phase_next == PH_S14 || phase_next == PH_S12)
                        begin
                            ch_v[n_v] = b64_char(carry_next);
                            n_v       = n_v + RES_W'(1);
                        end
                        ch_v[n_v]  = CH_DASH;
                        n_v        = n_v + RES_W'(1);
                        b64_next   = 1'b0;
                        carry_next = '0;
                        phase_next = PH_S10;
                    end
                    ch_v[n_v] = cp[6:0];
                    n_v       = n_v + RES_W'(1);
                    if (cp[6:0] == CH_AMP)
                    begin
                        ch_v[n_v] = CH_DASH;
                        n_v       = n_v + RES_W'(1);
                    end
                end
            end
            // end of name closes an open run
            if (eon)
            begin
                if (b64_next)
                begin
                    if (phase_next == PH_S14 || phase_next == PH_S12)
                    begin
                        ch_v[n_v] = b64_char(carry_next);
                        n_v       = n_v + RES_W'(1);
                    end
                    ch_v[n_v] = CH_DASH;
                    n_v       = n_v + RES_W'(1);
                end
                b64_next   = 1'b0;
                carry_next = '0;
                phase_next = PH_S10;
                acc_next   = '0;
                cl_next    = '0;
                seq_next   = '0;
            end
        end
    end

    // output side
    assign last_now      = ({1'b0, idx_reg} == 4'(cnt_reg) - 4'd1);
    assign out_fire      = vld_reg && char_ch.ready;
    assign byte_ch.ready = !vld_reg || (char_ch.ready && last_now);
    assign in_fire       = byte_ch.valid && byte_ch.ready;

    assign char_ch.valid     = vld_reg;
    assign char_ch.out_char  = chars_reg[idx_reg];
    assign char_ch.run_last  = last_now;
    assign char_ch.out_end   = end_reg && last_now;
    assign char_ch.bad_input = bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg   <= SEP_RESET;
            b64_reg   <= 1'b0;
            carry_reg <= '0;
            phase_reg <= PH_S10;
            acc_reg   <= '0;
            cl_reg    <= '0;
            seq_reg   <= '0;
            disc_reg  <= 1'b0;
            vld_reg   <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (wr_en)
                sep_reg <= wr_data;
            if (in_fire)
            begin
                b64_reg   <= b64_next;
                carry_reg <= carry_next;
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                cl_reg    <= cl_next;
                seq_reg   <= seq_next;
                disc_reg  <= disc_next;
            end
            // a new byte is taken only when the buffer is empty or as its last word leaves
            if (in_fire && n_v != '0)
            begin
                vld_reg <= 1'b1;
                idx_reg <= '0;
                cnt_reg <= n_v;
            end
            else if (out_fire)
            begin
                if (last_now)
                    vld_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    // payload of the result buffer
    always_ff @(posedge clk)
    begin
        if (in_fire && n_v != '0)
        begin
            for (int i = 0; i < MAX_RES; i++)
                chars_reg[i] <= ch_v[i];
            end_reg <= eon;
            bad_reg <= bad_v;
        end
    end

endmodule

// ===== rtl/u8mu7_checker.sv =====
// ----------------------------------------------------------------------------
// u8mu7_checker
// Port-level checks on the encoder's output framing, bound to the top level.
// ----------------------------------------------------------------------------
module u8mu7_checker
    import u8mu7_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input char_t      out_char,
    input logic       run_last,
    input logic       out_end,
    input logic       bad_input
);

    // an error word stands alone and carries no character
    a_bad_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_input |-> run_last && out_char == 7'd0)
        else $error("error word not alone");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_end |-> run_last)
        else $error("out_end without run_last");

    // characters of one byte leave back to back
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid && !bad_input)
        else $error("gap inside a byte's characters");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char))
        else $error("stalled word changed");

endmodule

bind utf8_to_modified_utf7_encoder u8mu7_checker u_u8mu7_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (char_ch.valid),
    .out_ready (char_ch.ready),
    .out_char  (char_ch.out_char),
    .run_last  (char_ch.run_last),
    .out_end   (char_ch.out_end),
    .bad_input (char_ch.bad_input)
);

// ===== test/utf8_to_modified_utf7_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_to_modified_utf7_encoder_tb
// Feeds UTF-8 name components into the encoder and checks every modified
// UTF-7 character word against an in-bench model of the encoding. Runs a
// short directed set, then mostly well-formed random names with some
// malformed ones, under several separator settings and random gaps on
// both channels.
// ----------------------------------------------------------------------------
module utf8_to_modified_utf7_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8mu7_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_WORDS   = 18;
    localparam int NUM_PHASES    = 5;

    typedef struct packed {
        logic [7:0] data;
        logic       name_end;
    } byte_word_t;

    typedef struct packed {
        char_t ch;
        logic  run_last;
        logic  out_end;
        logic  bad;
    } char_word_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       wr_en;
    logic [6:0] wr_data;

    u8mu7_byte_if byte_ch ();
    u8mu7_char_if char_ch ();

    utf8_to_modified_utf7_encoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .char_ch (char_ch),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    byte_word_t  pending_bytes [$];
    char_word_t  expected_chars [$];
    logic [7:0]  name_bytes [$];
    int          cycle_cnt    = 0;
    int          words_in     = 0;
    int          words_queued = 0;
    int          mismatches   = 0;

    // encoder model state
    string       b64_alpha =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+,=";
    logic [6:0]  sep_model;
    logic        in_b64;
    logic [5:0]  b64_carry;
    phase_t      b64_phase;
    logic [30:0] cp_accum;
    logic [2:0]  cont_left;
    logic [2:0]  seq_len;
    logic        discarding;
    char_word_t  step_buf [MAX_RES];
    int          step_n;

    function automatic char_t b64_at(logic [5:0] v);
        return char_t'(b64_alpha[int'(v)]);
    endfunction

    function automatic int shift_of(phase_t p);
        int s;
        case (p)
            PH_S14:  s = 14;
            PH_S12:  s = 12;
            default: s = 10;
        endcase
        return s;
    endfunction

    task automatic put_char(char_t c);
        if (step_n < MAX_RES)
        begin
            step_buf[step_n] = '{ch: c, run_last: 1'b0, out_end: 1'b0, bad: 1'b0};
            step_n++;
        end
    endtask

    task automatic clear_name();
        in_b64    = 1'b0;
        b64_carry = '0;
        b64_phase = PH_S10;
        cp_accum  = '0;
        cont_left = '0;
        seq_len   = '0;
    endtask

    task automatic close_b64();
        if (shift_of(b64_phase) > 10)
            put_char(b64_at(b64_carry));
        put_char(CH_DASH);
        in_b64    = 1'b0;
        b64_carry = '0;
        b64_phase = PH_S10;
    endtask

    task automatic bad_name(logic last);
        clear_name();
        discarding = !last;
        step_n     = 0;
        put_char('0);
        step_buf[0].bad = 1'b1;
    endtask

    task automatic emit_cp(logic [30:0] cp);
        int          k;
        logic [15:0] unit;
        if (cp < 31'h20 || cp >= 31'h7f)
        begin
            if (!in_b64)
            begin
                put_char(CH_AMP);
                in_b64    = 1'b1;
                b64_carry = '0;
                b64_phase = PH_S10;
            end
            unit = (cp > 31'hffff) ? CP_REPLACE : cp[15:0];
            k = shift_of(b64_phase);
            put_char(b64_at(b64_carry | 6'(unit >> k)));
            k -= 6;
            while (k >= 0)
            begin
                put_char(b64_at(6'(unit >> k)));
                k -= 6;
            end
            b64_carry = 6'(unit << (-k));
            k += 16;
            b64_phase = (k == 14) ? PH_S14 : (k == 12) ? PH_S12 : PH_S10;
        end
        else
        begin
            if (in_b64)
                close_b64();
            put_char(cp[6:0]);
            if (cp[6:0] == CH_AMP)
                put_char(CH_DASH);
        end
    endtask

    // works out the character words caused by one accepted byte
    task automatic encode_byte(logic [7:0] c, logic last);
        logic hold;
        int   i;
        step_n = 0;
        hold   = 1'b0;
        if (discarding)
        begin
            if (last)
            begin
                discarding = 1'b0;
                clear_name();
            end
            hold = 1'b1;
        end
        else if (cont_left == 0)
        begin
            if (!in_b64 && c == {1'b0, sep_model})
            begin
                put_char(CH_AMP);
                put_char(CH_UPPER_A);
                put_char(b64_at({2'b00, c[7:4]}));
                put_char(b64_at({c[3:0], 2'b00}));
                put_char(CH_DASH);
            end
            else if (c < 8'h80)
                emit_cp(31'(c));
            else if (c < 8'hc2 || c >= 8'hfe)
            begin
                bad_name(last);
                hold = 1'b1;
            end
            else
            begin
                if (c < 8'he0)
                begin
                    cp_accum = 31'(c[4:0]);
                    seq_len  = 3'd1;
                end
                else if (c < 8'hf0)
                begin
                    cp_accum = 31'(c[3:0]);
                    seq_len  = 3'd2;
                end
                else if (c < 8'hf8)
                begin
                    cp_accum = 31'(c[2:0]);
                    seq_len  = 3'd3;
                end
                else if (c < 8'hfc)
                begin
                    cp_accum = 31'(c[1:0]);
                    seq_len  = 3'd4;
                end
                else
                begin
                    cp_accum = 31'(c[0]);
                    seq_len  = 3'd5;
                end
                cont_left = seq_len;
                // a lead byte that ends the name is a cut-off sequence
                if (last)
                    bad_name(last);
                hold = 1'b1;
            end
        end
        else
        begin
            if (c[7:6] != 2'b10)
            begin
                bad_name(last);
                hold = 1'b1;
            end
            else
            begin
                cp_accum  = {cp_accum[24:0], c[5:0]};
                cont_left = cont_left - 3'd1;
                if (cont_left != 0)
                begin
                    if (last)
                        bad_name(last);
                    hold = 1'b1;
                end
                else if (seq_len > 1 && seq_len <= 5 &&
                         (cp_accum >> (int'(seq_len) * 5 + 1)) == 0)
                begin
                    // overlong form
                    bad_name(last);
                    hold = 1'b1;
                end
                else
                begin
                    emit_cp(cp_accum);
                    cp_accum = '0;
                    seq_len  = '0;
                end
            end
        end
        if (!hold && last)
        begin
            if (in_b64)
                close_b64();
            clear_name();
        end
        if (step_n > 0)
        begin
            step_buf[step_n - 1].run_last = 1'b1;
            step_buf[step_n - 1].out_end  = last;
        end
        for (i = 0; i < step_n; i++)
            expected_chars.insert(expected_chars.size(), step_buf[i]);
    endtask

    // no gaps while a middle stretch of words goes through
    function automatic logic take_gap();
        if (words_in >= 60 && words_in < 100)
            return 1'b0;
        return $urandom_range(0, 99) < 9;
    endfunction

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    always @(posedge clk)
    begin : drive_bytes
        byte_word_t next_word;
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                encode_byte(byte_ch.in_byte, byte_ch.name_end);
                words_in <= words_in + 1;
            end
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (pending_bytes.size() != 0 && !take_gap())
                begin
                    next_word = pending_bytes.pop_front();
                    byte_ch.valid    <= 1'b1;
                    byte_ch.in_byte  <= next_word.data;
                    byte_ch.name_end <= next_word.name_end;
                end
                else
                    byte_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_chars
        char_word_t got;
        char_word_t want;
        if (!rst_n)
            char_ch.ready <= 1'b0;
        else
        begin
            if (char_ch.valid && char_ch.ready)
            begin
                got = '{ch: char_ch.out_char, run_last: char_ch.run_last,
                        out_end: char_ch.out_end, bad: char_ch.bad_input};
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected word, got char %02h last %b end %b bad %b",
                             $time, got.ch, got.run_last, got.out_end, got.bad);
                    mismatches++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected char %02h last %b end %b bad %b, got %02h %b %b %b",
                                 $time, want.ch, want.run_last, want.out_end, want.bad,
                                 got.ch, got.run_last, got.out_end, got.bad);
                        mismatches++;
                    end
                end
            end
            char_ch.ready <= !take_gap();
        end
    end

    task automatic queue_word(logic [7:0] b, logic last);
        byte_word_t w;
        w.data     = b;
        w.name_end = last;
        pending_bytes.insert(pending_bytes.size(), w);
        words_queued++;
    endtask

    task automatic add_name_byte(logic [7:0] b);
        name_bytes.insert(name_bytes.size(), b);
    endtask

    task automatic utf8_append(logic [30:0] cp, int n);
        int         i;
        logic [7:0] lead;
        if (n == 1)
            add_name_byte(8'(cp));
        else
        begin
            case (n)
                2:       lead = 8'hc0;
                3:       lead = 8'he0;
                4:       lead = 8'hf0;
                5:       lead = 8'hf8;
                default: lead = 8'hfc;
            endcase
            add_name_byte(lead | 8'(cp >> (6 * (n - 1))));
            for (i = n - 2; i >= 0; i--)
                add_name_byte(8'h80 | {2'b00, 6'(cp >> (6 * i))});
        end
    endtask

    task automatic random_char();
        int sel;
        int n;
        int r;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            add_name_byte({1'b0, sep_model});
        else if (sel < 14)
            add_name_byte({1'b0, CH_AMP});
        else if (sel < 36)
            add_name_byte(8'($urandom_range(32, 126)));
        else if (sel < 46)
        begin
            r = $urandom_range(0, 32);
            add_name_byte((r == 32) ? 8'h7f : 8'(r));
        end
        else if (sel < 64)
            utf8_append(31'($urandom_range(32'h80, 32'h7ff)), 2);
        else if (sel < 78)
            utf8_append(31'($urandom_range(32'h800, 32'hffff)), 3);
        else if (sel < 86)
            utf8_append(31'($urandom_range(32'h10000, 32'h1fffff)), 4);
        else if (sel < 89)
            utf8_append(31'($urandom_range(32'h200000, 32'h3ffffff)), 5);
        else if (sel < 92)
            utf8_append(31'($urandom_range(32'h4000000, 32'h7fffffff)), 6);
        else if (sel < 94)
        begin
            // overlong: value small enough for a shorter form
            n = $urandom_range(3, 6);
            utf8_append(31'($urandom_range(0, (1 << (5 * n - 4)) - 1)), n);
        end
        else if (sel < 96)
            add_name_byte(8'($urandom_range(0, 255)));
        else if (sel < 98)
        begin
            // lead byte followed by something that is not a continuation
            add_name_byte(8'($urandom_range(8'hc2, 8'hfd)));
            r = $urandom_range(0, 191);
            add_name_byte((r < 128) ? 8'(r) : 8'(r + 64));
        end
        else
        begin
            r = $urandom_range(0, 67);
            add_name_byte((r < 66) ? 8'(8'h80 + r) : 8'(8'hfe + r - 66));
        end
    endtask

    task automatic random_name();
        int n;
        int i;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
            random_char();
        // sometimes cut the name off inside a sequence
        if ($urandom_range(0, 99) < 4)
            add_name_byte(8'($urandom_range(8'hc2, 8'hfd)));
        for (i = 0; i < name_bytes.size(); i++)
            queue_word(name_bytes[i], i == name_bytes.size() - 1);
        name_bytes.delete();
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || byte_ch.valid || expected_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_separator(logic [6:0] v);
        @(posedge clk);
        wr_en     <= 1'b1;
        wr_data   <= v;
        sep_model = v;
        @(posedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int         ph;
        int         phase_start;
        logic [6:0] sep_next;
        byte_ch.valid    = 1'b0;
        byte_ch.in_byte  = '0;
        byte_ch.name_end = 1'b0;
        char_ch.ready    = 1'b0;
        wr_en            = 1'b0;
        wr_data          = '0;
        rst_n            = 1'b0;
        sep_model        = SEP_RESET;
        discarding       = 1'b0;
        clear_name();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // printable extremes, ampersand, separator escape, control char run
        queue_word(8'h41, 1'b0); queue_word(8'h20, 1'b0); queue_word(8'h7e, 1'b0);
        queue_word(8'h26, 1'b0); queue_word(8'h2f, 1'b0); queue_word(8'h00, 1'b1);
        // multi-byte forms, separator inside a run, surrogate-free max, above 0xffff
        queue_word(8'hc2, 1'b0); queue_word(8'h80, 1'b0); queue_word(8'h2f, 1'b0);
        queue_word(8'hef, 1'b0); queue_word(8'hbf, 1'b0); queue_word(8'hbf, 1'b0);
        queue_word(8'hf0, 1'b0); queue_word(8'h90, 1'b0); queue_word(8'h80, 1'b0);
        queue_word(8'h80, 1'b1);
        // bad lead at end, bad lead then dropped bytes
        queue_word(8'h80, 1'b1);
        queue_word(8'hc1, 1'b0); queue_word(8'h41, 1'b0); queue_word(8'h42, 1'b1);
        // overlong three-byte form, truncated sequence, top lead byte
        queue_word(8'he0, 1'b0); queue_word(8'h80, 1'b0); queue_word(8'h80, 1'b1);
        queue_word(8'hc2, 1'b1);
        queue_word(8'hff, 1'b1);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                case (ph)
                    1:       sep_next = 7'h00;
                    2:       sep_next = 7'h7f;
                    3:       sep_next = CH_AMP;
                    default: sep_next = 7'($urandom_range(33, 126));
                endcase
                wait_idle();
                write_separator(sep_next);
            end
            phase_start = words_queued;
            while (words_queued - phase_start < PHASE_WORDS)
                random_name();
        end

        wait_idle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

endmodule
